// File: rtl/rjd_pkg.sv
// ----------------------------------------------------------------------------
// rjd_pkg
// Shared constants, types and command/status structs of the RTT jump and
// drift filter.
// ----------------------------------------------------------------------------
package rjd_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int RTT_W      = 12;
  localparam int IN_W       = 16;
  localparam int MEAN_W     = RTT_W + FRAC_BITS;
  localparam int VAR_W      = 2 * RTT_W + FRAC_BITS;
  localparam int WIN_W      = 8;
  localparam int DEV_W      = 8;
  localparam int KSQ_W      = 2 * DEV_W;
  localparam int PROD_W     = KSQ_W + VAR_W;
  localparam int CNT_W      = 3;
  localparam int NUM_W      = 48;
  localparam int DIV_STEPS  = NUM_W / 2;
  localparam int STEP_W     = $clog2(DIV_STEPS + 1);
  localparam int DEPTH      = 5;
  localparam int IDX_W      = 3;
  localparam int TALLY_W    = IDX_W + 1;
  localparam int SUM_W      = RTT_W + IDX_W;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  localparam logic [RTT_W-1:0] RTT_CAP = RTT_W'(3000);

  localparam logic [WIN_W-1:0] WIN_LIMIT_RST   = WIN_W'(35);
  localparam logic [DEV_W-1:0] JUMP_DEVS_RST   = DEV_W'(40);
  localparam logic [DEV_W-1:0] DRIFT_DEVS_RST  = DEV_W'(56);
  localparam logic [CNT_W-1:0] DETECT_CNT_RST  = CNT_W'(5);

  typedef enum logic [1:0] {
    REG_WINDOW_LIMIT = 2'd0,
    REG_JUMP_DEVS    = 2'd1,
    REG_DRIFT_DEVS   = 2'd2,
    REG_DETECT_COUNT = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    DIV_MEAN    = 2'd0,
    DIV_VAR     = 2'd1,
    DIV_REBUILD = 2'd2
  } div_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MNUM,
    ST_MDIV,
    ST_SQ,
    ST_VNUM,
    ST_VDIV,
    ST_MULJ,
    ST_JDEC,
    ST_DSQ,
    ST_MULD,
    ST_DDEC,
    ST_RSUM,
    ST_RDIV,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [WIN_W-1:0] window_limit;
    logic [DEV_W-1:0] jump_devs;
    logic [DEV_W-1:0] drift_devs;
    logic [CNT_W-1:0] detect_count;
  } cfg_t;

  typedef struct packed {
    logic     accept;
    logic     div_start;
    div_sel_e div_sel;
    logic     div_capture;
    logic     sq_en;
    logic     sq_drift;
    logic     mul_en;
    logic     jdec;
    logic     ddec;
    logic     rb_start;
    logic     fin;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic zero_skip;
    logic j_beyond;
    logic j_decl;
    logic d_decl;
    logic rb_empty;
    logic out_pending;
  } dp_status_t;

endpackage

// File: rtl/rjd_div.sv
// ----------------------------------------------------------------------------
// rjd_div
// Iterative restoring divider, two quotient bits per cycle, 8-bit divisor.
// ----------------------------------------------------------------------------
module rjd_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rjd_pkg::NUM_W-1:0] num_i,
  input  logic [rjd_pkg::WIN_W-1:0] den_i,
  output logic                      done_o,
  output logic [rjd_pkg::NUM_W-1:0] quo_o
);
  import rjd_pkg::*;

  logic [NUM_W-1:0]  num_q, num_d, quo_q, quo_d;
  logic [WIN_W-1:0]  den_q, rem_q, rem_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;

  logic [WIN_W:0]    ra, rb, ra2, rb2;
  logic              ge_a, ge_b;

  always_comb begin
    ra   = {rem_q, num_q[NUM_W-1]};
    ge_a = ra >= {1'b0, den_q};
    ra2  = ge_a ? ra - {1'b0, den_q} : ra;
    rb   = {ra2[WIN_W-1:0], num_q[NUM_W-2]};
    ge_b = rb >= {1'b0, den_q};
    rb2  = ge_b ? rb - {1'b0, den_q} : rb;
  end

  always_comb begin
    num_d  = num_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = num_i;
      quo_d  = '0;
      rem_d  = '0;
      cnt_d  = STEP_W'(DIV_STEPS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[NUM_W-3:0], 2'b00};
      quo_d = {quo_q[NUM_W-3:0], ge_a, ge_b};
      rem_d = rb2[WIN_W-1:0];
      cnt_d = cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: rtl/rjd_datapath.sv
// ----------------------------------------------------------------------------
// rjd_datapath
// Filter state, squaring and threshold products, outlier stores, rebuild
// and the output register.
// ----------------------------------------------------------------------------
module rjd_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rjd_pkg::dp_cmd_t          cmd_i,
  output rjd_pkg::dp_status_t       status_o,
  input  rjd_pkg::cfg_t             cfg_i,
  input  logic [rjd_pkg::IN_W-1:0]  rtt_sample_ms_i,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic [rjd_pkg::RTT_W-1:0] rtt_estimate_ms_o,
  output logic [rjd_pkg::RTT_W-1:0] average_ms_o,
  output logic                      jump_found_o,
  output logic                      drift_found_o,
  output logic                      sample_ignored_o
);
  import rjd_pkg::*;

  logic                 seen_q;
  logic [MEAN_W-1:0]    mean_q, old_mean_q;
  logic [VAR_W-1:0]     var_q, old_var_q;
  logic [RTT_W-1:0]     peak_q, x_q;
  logic [WIN_W-1:0]     wcnt_q, c_q;
  logic signed [TALLY_W-1:0] jtally_q;
  logic [IDX_W-1:0]     dtally_q, rb_len_q;
  logic                 rb_jump_q, dpos_q;
  logic [VAR_W-1:0]     sq_q;
  logic [KSQ_W-1:0]     ksq_q;
  logic [PROD_W-1:0]    prod_q;
  logic                 jf_q, df_q, ign_q;
  logic [RTT_W-1:0]     jstore_q [DEPTH];
  logic [RTT_W-1:0]     dstore_q [DEPTH];

  logic                 out_valid_q;
  logic [RTT_W-1:0]     est_q, avg_q;
  logic                 jf_out_q, df_out_q, ign_out_q;

  logic                 div_done;
  logic [NUM_W-1:0]     div_quo, div_num;
  logic [WIN_W-1:0]     div_den;

  // input side
  logic                 zero_skip;
  logic [RTT_W-1:0]     x_sat;
  logic [WIN_W-1:0]     c_eff, wcnt_next;
  logic [WIN_W:0]       wcnt_inc;
  logic [WIN_W-1:0]     wcnt_decl;

  assign zero_skip = !seen_q && (rtt_sample_ms_i == '0);
  assign x_sat     = (rtt_sample_ms_i > IN_W'(RTT_CAP)) ? RTT_CAP
                                                        : rtt_sample_ms_i[RTT_W-1:0];
  assign c_eff     = (wcnt_q > WIN_W'(1)) ? wcnt_q : WIN_W'(1);
  assign wcnt_inc  = {1'b0, wcnt_q} + (WIN_W+1)'(1);
  assign wcnt_next = (wcnt_inc > {1'b0, cfg_i.window_limit}) ? cfg_i.window_limit
                                                             : wcnt_inc[WIN_W-1:0];
  assign wcnt_decl = WIN_W'(cfg_i.detect_count) + WIN_W'(1);

  // squaring of deviations
  logic [MEAN_W-1:0]    xq, pq, mag;
  logic [2*MEAN_W-1:0]  mag_sq;
  logic [DEV_W-1:0]     k_sel;
  logic                 x_ge_mean;

  assign xq        = {x_q, FRAC_BITS'(0)};
  assign pq        = {peak_q, FRAC_BITS'(0)};
  assign x_ge_mean = xq >= mean_q;
  always_comb begin
    if (cmd_i.sq_drift) begin
      mag = pq - mean_q;
    end else begin
      mag = x_ge_mean ? xq - mean_q : mean_q - xq;
    end
  end
  assign mag_sq = mag * mag;
  assign k_sel  = cmd_i.sq_drift ? cfg_i.drift_devs : cfg_i.jump_devs;

  logic beyond;
  assign beyond = {(PROD_W-VAR_W-8)'(0), sq_q, 8'd0} > prod_q;

  // jump tally
  logic                      j_pos, j_mis, j_room, j_dcl;
  logic signed [TALLY_W-1:0] jt0, jt1;
  logic [TALLY_W-1:0]        ja0_w, ja1_w;
  logic [IDX_W-1:0]          ja0, ja1;

  always_comb begin
    j_pos  = mean_q >= xq;
    j_mis  = (j_pos == jtally_q[TALLY_W-1]);
    jt0    = j_mis ? '0 : jtally_q;
    ja0_w  = jt0[TALLY_W-1] ? TALLY_W'(-jt0) : TALLY_W'(jt0);
    ja0    = ja0_w[IDX_W-1:0];
    j_room = ja0 < IDX_W'(DEPTH);
    jt1    = jt0;
    if (j_room) begin
      jt1 = j_pos ? jt0 + TALLY_W'(1) : jt0 - TALLY_W'(1);
    end
    ja1_w  = jt1[TALLY_W-1] ? TALLY_W'(-jt1) : TALLY_W'(jt1);
    ja1    = ja1_w[IDX_W-1:0];
    j_dcl  = ja1 >= cfg_i.detect_count;
  end

  // drift tally
  logic             d_beyond, d_room, d_dcl;
  logic [IDX_W-1:0] dt1;

  assign d_beyond = dpos_q && beyond;
  assign d_room   = dtally_q < IDX_W'(DEPTH);
  assign dt1      = d_room ? dtally_q + IDX_W'(1) : dtally_q;
  assign d_dcl    = dt1 >= cfg_i.detect_count;

  // rebuild: sum and max over the first entries of the chosen store
  logic [SUM_W-1:0] rb_sum;
  logic [RTT_W-1:0] rb_max, rb_e;

  always_comb begin
    rb_sum = '0;
    rb_max = '0;
    rb_e   = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rb_e = rb_jump_q ? jstore_q[i] : dstore_q[i];
      if (IDX_W'(i) < rb_len_q) begin
        rb_sum = rb_sum + SUM_W'(rb_e);
        if (rb_e > rb_max) begin
          rb_max = rb_e;
        end
      end
    end
  end

  // divider operands
  logic [WIN_W-1:0] c_m1, c_half;
  assign c_m1   = c_q - WIN_W'(1);
  assign c_half = c_q >> 1;

  always_comb begin
    unique case (cmd_i.div_sel)
      DIV_MEAN: begin
        div_num = NUM_W'(c_m1 * mean_q) + NUM_W'(xq) + NUM_W'(c_half);
        div_den = c_q;
      end
      DIV_VAR: begin
        div_num = NUM_W'(c_m1 * var_q) + NUM_W'(sq_q) + NUM_W'(c_half);
        div_den = c_q;
      end
      DIV_REBUILD: begin
        div_num = NUM_W'({rb_sum, FRAC_BITS'(0)}) + NUM_W'(rb_len_q >> 1);
        div_den = WIN_W'(rb_len_q);
      end
      default: begin
        div_num = '0;
        div_den = WIN_W'(1);
      end
    endcase
  end

  rjd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= 1'b0;
      mean_q      <= '0;
      var_q       <= '0;
      peak_q      <= '0;
      wcnt_q      <= WIN_W'(1);
      jtally_q    <= '0;
      dtally_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept && !zero_skip) begin
        seen_q <= 1'b1;
        wcnt_q <= wcnt_next;
      end
      if (cmd_i.sq_en && !cmd_i.sq_drift && (x_q > peak_q)) begin
        peak_q <= x_q;
      end
      if (cmd_i.div_capture && div_done) begin
        unique case (cmd_i.div_sel)
          DIV_MEAN:    mean_q <= div_quo[MEAN_W-1:0];
          DIV_VAR:     var_q  <= div_quo[VAR_W-1:0];
          DIV_REBUILD: mean_q <= div_quo[MEAN_W-1:0];
          default:     ;
        endcase
      end
      if (cmd_i.jdec) begin
        if (beyond) begin
          if (j_dcl) begin
            wcnt_q   <= wcnt_decl;
            jtally_q <= '0;
          end else begin
            jtally_q <= jt1;
            mean_q   <= old_mean_q;
            var_q    <= old_var_q;
          end
        end else begin
          jtally_q <= '0;
        end
      end
      if (cmd_i.ddec) begin
        if (d_beyond && d_dcl) begin
          wcnt_q   <= wcnt_decl;
          dtally_q <= '0;
        end else if (d_beyond) begin
          dtally_q <= dt1;
        end else begin
          dtally_q <= '0;
        end
      end
      if (cmd_i.rb_start) begin
        peak_q <= rb_max;
      end
      if (cmd_i.fin) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x_q        <= x_sat;
      c_q        <= c_eff;
      old_mean_q <= mean_q;
      old_var_q  <= var_q;
      ign_q      <= zero_skip;
      jf_q       <= 1'b0;
      df_q       <= 1'b0;
    end
    if (cmd_i.sq_en) begin
      sq_q  <= mag_sq[FRAC_BITS +: VAR_W];
      ksq_q <= k_sel * k_sel;
      dpos_q <= pq > mean_q;
    end
    if (cmd_i.mul_en) begin
      prod_q <= ksq_q * var_q;
    end
    if (cmd_i.jdec && beyond) begin
      if (j_room) begin
        jstore_q[ja0] <= x_q;
      end
      if (j_dcl) begin
        jf_q      <= 1'b1;
        rb_jump_q <= 1'b1;
        rb_len_q  <= ja1;
      end
    end
    if (cmd_i.ddec && d_beyond) begin
      if (d_room) begin
        dstore_q[dtally_q] <= x_q;
      end
      if (d_dcl) begin
        df_q      <= 1'b1;
        rb_jump_q <= 1'b0;
        rb_len_q  <= dt1;
      end
    end
    if (cmd_i.fin) begin
      est_q     <= peak_q;
      avg_q     <= mean_q[MEAN_W-1:FRAC_BITS];
      jf_out_q  <= jf_q;
      df_out_q  <= df_q;
      ign_out_q <= ign_q;
    end
  end

  assign status_o.div_done    = div_done;
  assign status_o.zero_skip   = zero_skip;
  assign status_o.j_beyond    = beyond;
  assign status_o.j_decl      = beyond && j_dcl;
  assign status_o.d_decl      = d_beyond && d_dcl;
  assign status_o.rb_empty    = (rb_len_q == '0);
  assign status_o.out_pending = out_valid_q;

  assign out_valid_o       = out_valid_q;
  assign rtt_estimate_ms_o = est_q;
  assign average_ms_o      = avg_q;
  assign jump_found_o      = jf_out_q;
  assign drift_found_o     = df_out_q;
  assign sample_ignored_o  = ign_out_q;

endmodule

// File: rtl/rjd_ctrl.sv
// ----------------------------------------------------------------------------
// rjd_ctrl
// Sequencer: steps one sample through mean, variance, jump, drift and
// rebuild phases.
// ----------------------------------------------------------------------------
module rjd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                out_ready_i,
  input  rjd_pkg::dp_status_t status_i,
  output rjd_pkg::dp_cmd_t    cmd_o
);
  import rjd_pkg::*;

  state_e state_q, state_d;
  logic   from_jump_q, from_jump_d;
  logic   fin_ok;

  assign fin_ok = !status_i.out_pending || out_ready_i;

  always_comb begin
    state_d     = state_q;
    from_jump_d = from_jump_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.zero_skip ? ST_FIN : ST_MNUM;
        end
      end
      ST_MNUM: state_d = ST_MDIV;
      ST_MDIV: if (status_i.div_done) state_d = ST_SQ;
      ST_SQ:   state_d = ST_VNUM;
      ST_VNUM: state_d = ST_VDIV;
      ST_VDIV: if (status_i.div_done) state_d = ST_MULJ;
      ST_MULJ: state_d = ST_JDEC;
      ST_JDEC: begin
        priority if (!status_i.j_beyond) begin
          state_d = ST_DSQ;
        end else if (status_i.j_decl) begin
          state_d     = ST_RSUM;
          from_jump_d = 1'b1;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_DSQ:  state_d = ST_MULD;
      ST_MULD: state_d = ST_DDEC;
      ST_DDEC: begin
        if (status_i.d_decl) begin
          state_d     = ST_RSUM;
          from_jump_d = 1'b0;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_RSUM: begin
        if (status_i.rb_empty) begin
          state_d = from_jump_q ? ST_DSQ : ST_FIN;
        end else begin
          state_d = ST_RDIV;
        end
      end
      ST_RDIV: begin
        if (status_i.div_done) begin
          state_d = from_jump_q ? ST_DSQ : ST_FIN;
        end
      end
      ST_FIN:  if (fin_ok) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.div_sel = DIV_MEAN;
    in_ready_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_MNUM: cmd_o.div_start = 1'b1;
      ST_MDIV: cmd_o.div_capture = 1'b1;
      ST_SQ:   cmd_o.sq_en = 1'b1;
      ST_VNUM: begin
        cmd_o.div_sel   = DIV_VAR;
        cmd_o.div_start = 1'b1;
      end
      ST_VDIV: begin
        cmd_o.div_sel     = DIV_VAR;
        cmd_o.div_capture = 1'b1;
      end
      ST_MULJ: cmd_o.mul_en = 1'b1;
      ST_JDEC: cmd_o.jdec = 1'b1;
      ST_DSQ: begin
        cmd_o.sq_en    = 1'b1;
        cmd_o.sq_drift = 1'b1;
      end
      ST_MULD: cmd_o.mul_en = 1'b1;
      ST_DDEC: cmd_o.ddec = 1'b1;
      ST_RSUM: begin
        cmd_o.div_sel   = DIV_REBUILD;
        cmd_o.rb_start  = 1'b1;
        cmd_o.div_start = !status_i.rb_empty;
      end
      ST_RDIV: begin
        cmd_o.div_sel     = DIV_REBUILD;
        cmd_o.div_capture = 1'b1;
      end
      ST_FIN:  cmd_o.fin = fin_ok;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      from_jump_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      from_jump_q <= from_jump_d;
    end
  end

endmodule

// File: rtl/rtt_jump_drift_filter_unit.sv
// ----------------------------------------------------------------------------
// rtt_jump_drift_filter_unit
// RTT filter with running mean/variance, peak tracking and jump/drift
// detection.
// ----------------------------------------------------------------------------
// Usage:
//  - input channel: rtt_sample_ms_i with in_valid_i/in_ready_o; one beat is
//    one RTT sample in ms, values above 3000 are clipped
//  - output channel: one result beat per input beat (estimate, average,
//    jump/drift flags, ignored flag) with out_valid_o/out_ready_i
//  - APB port: window_limit at 0x0, jump_devs_q4 at 0x4, drift_devs_q4 at
//    0x8, detect_count at 0xC; write only while idle
//  - one sample at a time: a leading zero sample goes straight to the output,
//    a normal sample runs the mean, variance, jump and drift steps (an
//    unconfirmed outlier skips the drift test), and a jump rebuild may be
//    followed by a drift rebuild; every division (mean, variance, and the
//    rebuilt mean) uses the shared 2-bit-per-cycle divider
//  - the output register decouples the sides: a new sample is taken while
//    the previous result waits; a stalled receiver holds the next result in
//    its final step until the register frees
//  - reset clears the filter state and loads the register defaults; the
//    outlier buffers need no clearing, as only written entries are read
// ----------------------------------------------------------------------------
module rtt_jump_drift_filter_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rjd_pkg::ADDR_W-1:0] paddr,
  input  logic [rjd_pkg::DATA_W-1:0] pwdata,
  output logic [rjd_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [rjd_pkg::IN_W-1:0]   rtt_sample_ms_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [rjd_pkg::RTT_W-1:0]  rtt_estimate_ms_o,
  output logic [rjd_pkg::RTT_W-1:0]  average_ms_o,
  output logic                       jump_found_o,
  output logic                       drift_found_o,
  output logic                       sample_ignored_o
);
  import rjd_pkg::*;

  cfg_t       cfg_q;
  dp_cmd_t    cmd;
  dp_status_t status;
  reg_idx_e   reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_limit <= WIN_LIMIT_RST;
      cfg_q.jump_devs    <= JUMP_DEVS_RST;
      cfg_q.drift_devs   <= DRIFT_DEVS_RST;
      cfg_q.detect_count <= DETECT_CNT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_WINDOW_LIMIT: cfg_q.window_limit <= pwdata[WIN_W-1:0];
        REG_JUMP_DEVS:    cfg_q.jump_devs    <= pwdata[DEV_W-1:0];
        REG_DRIFT_DEVS:   cfg_q.drift_devs   <= pwdata[DEV_W-1:0];
        REG_DETECT_COUNT: cfg_q.detect_count <= pwdata[CNT_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WINDOW_LIMIT: prdata = DATA_W'(cfg_q.window_limit);
      REG_JUMP_DEVS:    prdata = DATA_W'(cfg_q.jump_devs);
      REG_DRIFT_DEVS:   prdata = DATA_W'(cfg_q.drift_devs);
      REG_DETECT_COUNT: prdata = DATA_W'(cfg_q.detect_count);
      default:          prdata = '0;
    endcase
  end

  rjd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rjd_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_i             (cfg_q),
    .rtt_sample_ms_i   (rtt_sample_ms_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .rtt_estimate_ms_o (rtt_estimate_ms_o),
    .average_ms_o      (average_ms_o),
    .jump_found_o      (jump_found_o),
    .drift_found_o     (drift_found_o),
    .sample_ignored_o  (sample_ignored_o)
  );

endmodule
